FILE: rtl/fupd_pkg.sv
// Shared types, constants and character helpers for the file URI percent decoder.
`default_nettype none

package fupd_pkg;

  // Fixed strings and characters
  localparam int unsigned PrefixLen = 7;
  localparam int unsigned HostLen   = 9;
  localparam logic [7:0]  ChSlash   = 8'h2F;
  localparam logic [7:0]  ChPercent = 8'h25;

  // Result queue sizing
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);
  localparam int unsigned MaxRes = 3;

  // Parser phase
  typedef enum logic [3:0] {
    PH_PREFIX  = 4'b0001,
    PH_AUTH    = 4'b0010,
    PH_PATH    = 4'b0100,
    PH_SWALLOW = 4'b1000
  } phase_t;

  // Escape hold codes
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPct   = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] match_idx;
    logic [1:0] pend;
    logic [3:0] nib;
    logic [7:0] dchar;
  } st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       status;
    logic       last;
  } res_t;

  localparam st_t StReset = '{phase: PH_PREFIX, match_idx: 4'd0, pend: PendNone,
                              nib: 4'd0, dchar: 8'd0};

  // Character of "file://" at a position
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66;  // f
      3'd1:    ch = 8'h69;  // i
      3'd2:    ch = 8'h6C;  // l
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h3A;  // :
      3'd5:    ch = 8'h2F;  // /
      3'd6:    ch = 8'h2F;  // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character of "localhost" at a position
  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h6C;  // l
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h63;  // c
      4'd3:    ch = 8'h61;  // a
      4'd4:    ch = 8'h6C;  // l
      4'd5:    ch = 8'h68;  // h
      4'd6:    ch = 8'h6F;  // o
      4'd7:    ch = 8'h73;  // s
      4'd8:    ch = 8'h74;  // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_ascii(input logic [7:0] c);
    logic [7:0] r;
    if (c inside {[8'h41:8'h5A]}) r = c + 8'd32;
    else r = c;
    return r;
  endfunction

  // Hex digit decode: {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) r = {1'b1, 4'(c - 8'h30)};
    else if (c inside {[8'h61:8'h66]}) r = {1'b1, 4'(c - 8'h57)};
    else if (c inside {[8'h41:8'h46]}) r = {1'b1, 4'(c - 8'h37)};
    else r = 5'd0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/file_uri_percent_decoder_core.sv
// Top level: input register, per-byte decode step and result queue.
// A byte waits in the input register; its results go to the queue whose head is out_*.
// Throughput: one byte per cycle while the eight-entry result queue has three free slots.
// A byte can give zero to three results; the queue absorbs bursts and back-pressure.
// Reset (rst_n low, synchronous) empties the queue and returns to prefix matching.
`default_nettype none

module file_uri_percent_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // out_status
  output logic            out_tlast   // out_last
);

  localparam int unsigned PtrW = fupd_pkg::QPtrW;
  localparam int unsigned CntW = fupd_pkg::QCntW;

  // Input stage
  logic       v_r, v_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       proc;

  // Parser state
  fupd_pkg::st_t       st_r, st_nxt;
  fupd_pkg::res_t [2:0] res;
  logic [1:0]          res_cnt;

  // Result queue
  fupd_pkg::res_t      q_mem [fupd_pkg::QDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                pop;
  logic [1:0]          push_n;

  // Process the held byte only when the queue can take a full burst
  assign proc      = v_r && (cnt_r <= CntW'(fupd_pkg::QDepth - fupd_pkg::MaxRes));
  assign in_tready = !v_r || proc;
  assign v_nxt     = in_tready ? in_tvalid : v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  fupd_step u_step (
    .c       (byte_r),
    .last    (last_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res),
    .res_cnt (res_cnt)
  );

  // Advance parser state per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= fupd_pkg::StReset;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // Queue bookkeeping
  assign pop        = out_tvalid && out_tready;
  assign push_n     = proc ? res_cnt : 2'd0;
  assign wr_ptr_nxt = wr_ptr_r + PtrW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + PtrW'(pop);
  assign cnt_nxt    = cnt_r + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write up to three results at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < fupd_pkg::MaxRes; i++) begin
      if (2'(i) < push_n) begin
        q_mem[wr_ptr_r + PtrW'(i)] <= res[i];
      end
    end
  end

  // Present the queue head
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_mem[rd_ptr_r].data;
  assign out_tuser  = q_mem[rd_ptr_r].status;
  assign out_tlast  = q_mem[rd_ptr_r].last;

  // Queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(fupd_pkg::QDepth))
    else $error("result queue overflow");

  // Empty queue has equal pointers
  a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> rd_ptr_r == wr_ptr_r)
    else $error("queue pointers disagree with count");

  // An escape is held only inside the path
  a_pend_path: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != fupd_pkg::PH_PATH |-> st_r.pend == fupd_pkg::PendNone)
    else $error("escape held outside path");

  // A processed byte with the last flag leaves the parser at prefix matching
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && last_r |=> st_r.phase == fupd_pkg::PH_PREFIX && st_r.match_idx == 4'd0)
    else $error("parser did not restart after final byte");

endmodule

`default_nettype wire

FILE: rtl/fupd_step.sv
// Per-byte parse and decode logic: next state and up to three results.
`default_nettype none

module fupd_step (
  input  wire logic [7:0]          c,
  input  wire logic                last,
  input  wire fupd_pkg::st_t       st,
  output fupd_pkg::st_t            st_nxt,
  output fupd_pkg::res_t [2:0]     res,
  output logic [1:0]               res_cnt
);

  logic [4:0]    hv;
  logic          reject;
  logic          do_path;
  logic          tail;
  logic [1:0]    pend_eff;
  logic [1:0]    n;
  logic [7:0]    pre_ch;
  logic [7:0]    host_ch;

  assign hv      = fupd_pkg::hex_val(c);
  assign pre_ch  = fupd_pkg::prefix_char(st.match_idx[2:0]);
  assign host_ch = fupd_pkg::host_char(st.match_idx);

  always_comb begin
    st_nxt   = st;
    res      = '0;
    n        = 2'd0;
    reject   = 1'b0;
    do_path  = 1'b0;
    tail     = 1'b0;
    pend_eff = st.pend;

    // Phase dispatch
    case (st.phase)
      fupd_pkg::PH_PREFIX: begin
        if (st.match_idx >= 4'(fupd_pkg::PrefixLen) || c != pre_ch) begin
          reject = 1'b1;
        end else begin
          st_nxt.match_idx = st.match_idx + 4'd1;
          if (st_nxt.match_idx == 4'(fupd_pkg::PrefixLen)) begin
            st_nxt.phase     = fupd_pkg::PH_AUTH;
            st_nxt.match_idx = 4'd0;
          end
          if (last) reject = 1'b1;
        end
      end
      fupd_pkg::PH_AUTH: begin
        if ((st.match_idx == 4'd0 || st.match_idx == 4'(fupd_pkg::HostLen)) &&
            c == fupd_pkg::ChSlash) begin
          st_nxt.phase = fupd_pkg::PH_PATH;
          pend_eff     = fupd_pkg::PendNone;
          do_path      = 1'b1;
        end else if (st.match_idx < 4'(fupd_pkg::HostLen) &&
                     fupd_pkg::fold_ascii(c) == host_ch) begin
          st_nxt.match_idx = st.match_idx + 4'd1;
          if (last) reject = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
      fupd_pkg::PH_PATH: begin
        do_path = 1'b1;
      end
      fupd_pkg::PH_SWALLOW: begin
        if (last) st_nxt = fupd_pkg::StReset;
      end
      default: begin
        st_nxt = fupd_pkg::StReset;
      end
    endcase

    // Path byte: resolve any held escape, then handle this byte
    if (do_path) begin
      st_nxt.pend = fupd_pkg::PendNone;
      if (pend_eff == fupd_pkg::PendDigit) begin
        if (hv[4]) begin
          res[n] = '{data: {st.nib, hv[3:0]}, status: 1'b0, last: 1'b0};
          n      = n + 2'd1;
        end else begin
          res[n] = '{data: fupd_pkg::ChPercent, status: 1'b0, last: 1'b0};
          n      = n + 2'd1;
          res[n] = '{data: st.dchar, status: 1'b0, last: 1'b0};
          n      = n + 2'd1;
          tail   = 1'b1;
        end
      end else if (pend_eff == fupd_pkg::PendPct) begin
        if (hv[4]) begin
          st_nxt.nib   = hv[3:0];
          st_nxt.dchar = c;
          st_nxt.pend  = fupd_pkg::PendDigit;
        end else begin
          res[n] = '{data: fupd_pkg::ChPercent, status: 1'b0, last: 1'b0};
          n      = n + 2'd1;
          tail   = 1'b1;
        end
      end else begin
        tail = 1'b1;
      end
      if (tail) begin
        if (c == fupd_pkg::ChPercent) begin
          st_nxt.pend = fupd_pkg::PendPct;
        end else begin
          res[n] = '{data: c, status: 1'b0, last: 1'b0};
          n      = n + 2'd1;
        end
      end
    end

    // Reject: single flagged result, then swallow or start over
    if (reject) begin
      res[n] = '{data: 8'd0, status: 1'b1, last: 1'b1};
      n      = n + 2'd1;
      if (last) begin
        st_nxt = fupd_pkg::StReset;
      end else begin
        st_nxt.phase     = fupd_pkg::PH_SWALLOW;
        st_nxt.match_idx = 4'd0;
      end
    end else if (last && st_nxt.phase == fupd_pkg::PH_PATH) begin
      // Flush held escape bytes literally and mark the final result
      if (st_nxt.pend != fupd_pkg::PendNone) begin
        res[n] = '{data: fupd_pkg::ChPercent, status: 1'b0, last: 1'b0};
        n      = n + 2'd1;
      end
      if (st_nxt.pend == fupd_pkg::PendDigit) begin
        res[n] = '{data: st_nxt.dchar, status: 1'b0, last: 1'b0};
        n      = n + 2'd1;
      end
      if (n != 2'd0) res[n - 2'd1].last = 1'b1;
      st_nxt = fupd_pkg::StReset;
    end

    res_cnt = n;
  end

endmodule

`default_nettype wire

FILE: sim/tb_file_uri_percent_decoder_core.sv
// Self-checking testbench for the file URI percent decoder core.
`default_nettype none

module tb_file_uri_percent_decoder_core;

  localparam logic [8*7-1:0] PrefixText = "file://";
  localparam logic [8*9-1:0] HostText   = "localhost";
  localparam int unsigned    RandomBytes = 24;
  localparam int unsigned    DrainLimit  = 5000;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;   // in_last
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tuser;  // out_status
  logic       out_tlast;  // out_last

  // Decoder state as the scoreboard tracks it
  fupd_pkg::phase_t ph;
  logic [3:0]       midx;
  logic [1:0]       pend;
  logic [3:0]       nib;
  logic [7:0]       dchar;

  fupd_pkg::res_t decoded_q[$];
  logic [7:0]     uri_buf[$];
  int unsigned    bytes_sent;
  int unsigned    results_seen;
  int unsigned    rejects_seen;
  int unsigned    fails;
  int unsigned    sink_hold;
  logic           res_taken;
  logic           idle_on;

  file_uri_percent_decoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case the handshake hangs
  initial begin
    #4000000;
    $display("[file_uri_percent_decoder_core] ERROR");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, 5) : 0;
  endfunction

  // Return {is_hex, value} for one character
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (low >= "a" && low <= "f") return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic st);
    fupd_pkg::res_t r;
    r.data   = b;
    r.status = st;
    r.last   = 1'b0;
    decoded_q.push_back(r);
  endfunction

  function automatic void mark_last();
    decoded_q[decoded_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void clear_state();
    ph    = fupd_pkg::PH_PREFIX;
    midx  = 4'd0;
    pend  = fupd_pkg::PendNone;
    nib   = 4'd0;
    dchar = 8'd0;
  endfunction

  // Decode one path byte; return the number of results it gives
  function automatic int unsigned decode_path(input logic [7:0] c);
    logic [4:0]  h;
    int unsigned n;
    h = nibble_of(c);
    n = 0;
    if (pend == fupd_pkg::PendDigit) begin
      pend = fupd_pkg::PendNone;
      if (h[4]) begin
        push_result({nib, h[3:0]}, 1'b0);
        return 1;
      end
      push_result(fupd_pkg::ChPercent, 1'b0);
      push_result(dchar, 1'b0);
      n = 2;
    end else if (pend == fupd_pkg::PendPct) begin
      pend = fupd_pkg::PendNone;
      if (h[4]) begin
        nib   = h[3:0];
        dchar = c;
        pend  = fupd_pkg::PendDigit;
        return 0;
      end
      push_result(fupd_pkg::ChPercent, 1'b0);
      n = 1;
    end
    // Hold a fresh '%', pass anything else through
    if (c == fupd_pkg::ChPercent) begin
      pend = fupd_pkg::PendPct;
    end else begin
      push_result(c, 1'b0);
      n++;
    end
    return n;
  endfunction

  // Work out the results of one accepted input transaction
  function automatic void decode_step(input logic [7:0] c, input logic lst);
    logic        rej;
    logic [7:0]  lc;
    int unsigned n;
    rej = 1'b0;
    n   = 0;
    lc  = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    case (ph)
      fupd_pkg::PH_PREFIX: begin
        if (midx >= fupd_pkg::PrefixLen ||
            c != PrefixText[8*(fupd_pkg::PrefixLen-1-midx) +: 8]) begin
          rej = 1'b1;
        end else begin
          midx = midx + 4'd1;
          if (midx == fupd_pkg::PrefixLen) begin
            ph   = fupd_pkg::PH_AUTH;
            midx = 4'd0;
          end
          if (lst) rej = 1'b1;
        end
      end
      fupd_pkg::PH_AUTH: begin
        if ((midx == 4'd0 || midx == fupd_pkg::HostLen) && c == fupd_pkg::ChSlash) begin
          ph   = fupd_pkg::PH_PATH;
          pend = fupd_pkg::PendNone;
          n    = decode_path(c);
        end else if (midx < fupd_pkg::HostLen &&
                     lc == HostText[8*(fupd_pkg::HostLen-1-midx) +: 8]) begin
          midx = midx + 4'd1;
          if (lst) rej = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      fupd_pkg::PH_PATH: n = decode_path(c);
      default: begin
        if (lst) clear_state();
        return;
      end
    endcase
    // Reject once, then swallow the rest of the URI
    if (rej) begin
      push_result(8'd0, 1'b1);
      mark_last();
      if (lst) begin
        clear_state();
      end else begin
        ph   = fupd_pkg::PH_SWALLOW;
        midx = 4'd0;
      end
      return;
    end
    // Flush held escape characters on the final byte
    if (lst && ph == fupd_pkg::PH_PATH) begin
      if (pend != fupd_pkg::PendNone) begin
        push_result(fupd_pkg::ChPercent, 1'b0);
        n++;
      end
      if (pend == fupd_pkg::PendDigit) begin
        push_result(dchar, 1'b0);
        n++;
      end
      if (n > 0) mark_last();
      clear_state();
    end
  endfunction

  // Offer one input transaction and wait for its acceptance
  task automatic send_byte(input logic [7:0] c, input logic lst);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tlast  = lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_step(c, lst);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the buffered URI, flagging its final byte
  task automatic send_uri();
    int unsigned k;
    for (k = 0; k < uri_buf.size(); k++) send_byte(uri_buf[k], k == uri_buf.size() - 1);
    uri_buf.delete();
  endtask

  task automatic push_text(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) uri_buf.push_back(s[k]);
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_uri();
  endtask

  // Append one hex digit in random case
  task automatic push_hex(input logic [3:0] v);
    logic [7:0] base;
    if (v < 4'd10) begin
      uri_buf.push_back("0" + v);
    end else begin
      base = $urandom_range(0, 1) ? "a" : "A";
      uri_buf.push_back(base + v - 4'd10);
    end
  endtask

  // Build a well-formed URI with a random path
  task automatic build_good_uri();
    int unsigned k;
    int unsigned tokens;
    logic [7:0]  ch;
    push_text("file://");
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < fupd_pkg::HostLen; k++) begin
        ch = HostText[8*(fupd_pkg::HostLen-1-k) +: 8];
        uri_buf.push_back($urandom_range(0, 1) ? (ch & 8'hDF) : ch);
      end
    end
    uri_buf.push_back(fupd_pkg::ChSlash);
    tokens = $urandom_range(0, 6);
    for (k = 0; k < tokens; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: uri_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        4, 5: begin
          uri_buf.push_back(fupd_pkg::ChPercent);
          push_hex(4'($urandom_range(0, 15)));
          push_hex(4'($urandom_range(0, 15)));
        end
        6: uri_buf.push_back(fupd_pkg::ChPercent);
        7: begin
          uri_buf.push_back(fupd_pkg::ChPercent);
          push_hex(4'($urandom_range(0, 15)));
        end
        default: uri_buf.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  task automatic test_prefix_and_authority();
    idle_on = 1'b1;
    send_text("FILE:");
    send_text("file://");
    send_text("file://lo");
    send_text("file://localhostx");
    send_text("file://h/");
    send_text("f");
  endtask

  task automatic test_path_escapes();
    idle_on = 1'b0;
    // Authority in mixed case, decoded escapes and extreme byte values
    push_text("file://LocalHOST/%41%6a%00%ff%FF");
    uri_buf.push_back(8'hFF);
    uri_buf.push_back(8'h01);
    send_uri();
    send_text("file:///%zz%4g%4%41%%41");
    idle_on = 1'b1;
    send_text("file:///%");
    send_text("file:///%7");
    send_text("file:///");
  endtask

  // Stall the result side long enough to fill the queue
  task automatic test_backpressure();
    int unsigned k;
    idle_on   = 1'b0;
    sink_hold = 40;
    push_text("file:///");
    for (k = 0; k < 12; k++) begin
      if (k == 5) begin
        uri_buf.push_back(fupd_pkg::ChPercent);
        push_hex(4'($urandom_range(0, 15)));
        push_hex(4'($urandom_range(0, 15)));
      end else begin
        uri_buf.push_back(8'($urandom_range(1, 255)));
      end
    end
    send_uri();
  endtask

  task automatic test_random_uris();
    int unsigned start;
    int unsigned kind;
    int unsigned k;
    int unsigned pos;
    int unsigned cut;
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 10) begin
        // Pure noise
        cut = $urandom_range(1, 8);
        for (k = 0; k < cut; k++) uri_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        build_good_uri();
        if (kind < 25) begin
          // Corrupt one byte near the head
          pos = $urandom_range(0, (uri_buf.size() > 18) ? 17 : uri_buf.size() - 1);
          uri_buf[pos] = 8'($urandom_range(1, 255));
        end else if (kind < 35) begin
          // Cut the URI short
          cut = $urandom_range(1, uri_buf.size());
          while (uri_buf.size() > cut) void'(uri_buf.pop_back());
        end
      end
      send_uri();
    end
  endtask

  // Check every accepted result transaction against the oldest prediction
  initial begin : result_check
    fupd_pkg::res_t want;
    res_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        res_taken = 1'b1;
        results_seen++;
        if (out_tuser) rejects_seen++;
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %0h out_status %0b out_last %0b",
                 out_tdata, out_tuser, out_tlast);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte mismatch: expected %0h actual %0h", want.data, out_tdata);
            fails++;
          end
          if (out_tuser !== want.status) begin
            $error("out_status mismatch: expected %0b actual %0b", want.status, out_tuser);
            fails++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last mismatch: expected %0b actual %0b", want.last, out_tlast);
            fails++;
          end
        end
      end
    end
  end

  // Drive out_tready: random stall after each result, plus long hold-offs on request
  initial begin : result_sink
    int unsigned stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (res_taken) begin
        res_taken = 1'b0;
        stall     = draw_gap();
      end
      if (sink_hold != 0) begin
        out_tready = 1'b0;
        sink_hold--;
      end else if (stall != 0) begin
        out_tready = 1'b0;
        stall--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  initial begin : main_seq
    int unsigned waited;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = 8'd0;
    in_tlast     = 1'b0;
    bytes_sent   = 0;
    results_seen = 0;
    rejects_seen = 0;
    fails        = 0;
    sink_hold    = 0;
    idle_on      = 1'b1;
    clear_state();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_prefix_and_authority();
    test_path_escapes();
    test_backpressure();
    test_random_uris();
    in_tvalid = 1'b0;

    // Drain outstanding results, then watch for stray ones
    waited = 0;
    while (decoded_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      fails++;
    end

    $display("Covered: %0d URI bytes in, %0d results checked (%0d rejections),",
             bytes_sent, results_seen, rejects_seen);
    $display("  prefix/authority errors, escapes, flushes and a full-queue stall.");
    if (fails == 0) begin
      $display("[file_uri_percent_decoder_core] OK");
    end else begin
      $display("[file_uri_percent_decoder_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
